// ===== rtl/core/cvs_pkg.sv =====
// ----------------------------------------------------------------------------
// cvs_pkg
// shared constants, codes and types of the checkpointed visited set
// ----------------------------------------------------------------------------
package cvs_pkg;

  localparam int unsigned ID_BITS       = 12;
  localparam int unsigned REF_BITS      = 16;
  localparam int unsigned CNT_BITS      = 16;
  localparam int unsigned KIND_BITS     = 3;
  localparam int unsigned ERR_BITS      = 2;
  localparam int unsigned TBL_DEPTH     = 1 << ID_BITS;
  localparam int unsigned LOG_DEPTH     = 4096;
  localparam int unsigned LOG_AW        = $clog2(LOG_DEPTH);
  localparam int unsigned LOG_PTR_BITS  = $clog2(LOG_DEPTH + 1);
  localparam int unsigned MARK_DEPTH    = 16;
  localparam int unsigned MARK_AW       = $clog2(MARK_DEPTH);
  localparam int unsigned MARK_PTR_BITS = $clog2(MARK_DEPTH + 1);
  localparam int unsigned APB_AW        = 3;
  localparam int unsigned APB_DW        = 32;

  // operation codes
  localparam logic [KIND_BITS-1:0] KIND_PUT    = 3'd0;
  localparam logic [KIND_BITS-1:0] KIND_COUNT  = 3'd1;
  localparam logic [KIND_BITS-1:0] KIND_LOOKUP = 3'd2;
  localparam logic [KIND_BITS-1:0] KIND_SET    = 3'd3;
  localparam logic [KIND_BITS-1:0] KIND_REVERT = 3'd4;
  localparam logic [KIND_BITS-1:0] KIND_COMMIT = 3'd5;

  // error codes
  localparam logic [ERR_BITS-1:0] ERR_OK        = 2'd0;
  localparam logic [ERR_BITS-1:0] ERR_NO_MARK   = 2'd1;
  localparam logic [ERR_BITS-1:0] ERR_MARK_FULL = 2'd2;
  localparam logic [ERR_BITS-1:0] ERR_LOG_FULL  = 2'd3;

  // register word index
  localparam logic REG_REF_START = 1'b0;

  typedef struct packed {
    logic                valid;
    logic [REF_BITS-1:0] ref_num;
  } tbl_entry_t;

  localparam int unsigned TBL_WIDTH = $bits(tbl_entry_t);

  typedef struct packed {
    logic [LOG_PTR_BITS-1:0] top;
    logic [CNT_BITS-1:0]     count;
  } mark_t;

  typedef struct packed {
    logic                we;
    logic [REF_BITS-1:0] ref_start;
  } cfg_t;

  typedef struct packed {
    logic                hit;
    logic [REF_BITS-1:0] ref_value;
    logic [CNT_BITS-1:0] element_count;
    logic [ERR_BITS-1:0] error;
  } result_t;

endpackage

// ===== rtl/core/cvs_in_if.sv =====
// ----------------------------------------------------------------------------
// cvs_in_if
// request channel: operation kind and process id
// ----------------------------------------------------------------------------
interface cvs_in_if;
  logic                             valid;
  logic                             ready;
  logic [cvs_pkg::KIND_BITS-1:0]    kind;
  logic [cvs_pkg::ID_BITS-1:0]      id;

  modport source (output valid, output kind, output id, input ready);
  modport sink   (input valid, input kind, input id, output ready);
endinterface

// ===== rtl/core/cvs_out_if.sv =====
// ----------------------------------------------------------------------------
// cvs_out_if
// result channel: hit flag, reference number, element count, error code
// ----------------------------------------------------------------------------
interface cvs_out_if;
  logic                          valid;
  logic                          ready;
  logic                          hit;
  logic [cvs_pkg::REF_BITS-1:0]  ref_value;
  logic [cvs_pkg::CNT_BITS-1:0]  element_count;
  logic [cvs_pkg::ERR_BITS-1:0]  error;

  modport source (output valid, output hit, output ref_value, output element_count,
                  output error, input ready);
  modport sink   (input valid, input hit, input ref_value, input element_count,
                  input error, output ready);
endinterface

// ===== rtl/core/cvs_ram.sv =====
// ----------------------------------------------------------------------------
// cvs_ram
// simple dual-port synchronous ram, one write and one registered read port
// ----------------------------------------------------------------------------
module cvs_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

// ===== rtl/core/cvs_ctrl.sv =====
// ----------------------------------------------------------------------------
// cvs_ctrl
// sequencer: table read-modify-write, checkpoint stack, undo-log walk
// ----------------------------------------------------------------------------
module cvs_ctrl (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  cvs_in_if.sink                              item_i,
  cvs_out_if.source                           res_o,
  input  cvs_pkg::cfg_t                       cfg_i,
  output logic                                tbl_we_o,
  output logic [cvs_pkg::ID_BITS-1:0]         tbl_waddr_o,
  output logic [cvs_pkg::TBL_WIDTH-1:0]       tbl_wdata_o,
  output logic [cvs_pkg::ID_BITS-1:0]         tbl_raddr_o,
  input  logic [cvs_pkg::TBL_WIDTH-1:0]       tbl_rdata_i,
  output logic                                log_we_o,
  output logic [cvs_pkg::LOG_AW-1:0]          log_waddr_o,
  output logic [cvs_pkg::ID_BITS-1:0]         log_wdata_o,
  output logic [cvs_pkg::LOG_AW-1:0]          log_raddr_o,
  input  logic [cvs_pkg::ID_BITS-1:0]         log_rdata_i
);
  import cvs_pkg::*;

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_EXEC  = 2'd2;
  localparam logic [1:0] ST_WALK  = 2'd3;

  logic [1:0]               state_q, state_d;
  logic [ID_BITS-1:0]       clr_ptr_q, clr_ptr_d;
  logic [KIND_BITS-1:0]     kind_q;
  logic [ID_BITS-1:0]       id_q;
  logic [LOG_PTR_BITS-1:0]  log_top_q, log_top_d;
  logic [MARK_PTR_BITS-1:0] depth_q, depth_d;
  logic [REF_BITS-1:0]      ref_q, ref_d;
  logic [CNT_BITS-1:0]      elem_q, elem_d;
  logic [LOG_PTR_BITS-1:0]  walk_ptr_q, walk_ptr_d;
  logic                     pend_q, pend_d;
  logic [LOG_PTR_BITS-1:0]  mtop_q, mtop_d;
  logic [CNT_BITS-1:0]      mcount_q, mcount_d;
  logic                     out_valid_q, out_valid_d;
  result_t                  res_q, res_d, res_n;
  mark_t                    mark_q [MARK_DEPTH];
  logic                     mark_we;
  mark_t                    mark_wdata;
  mark_t                    mark_top;
  logic [MARK_PTR_BITS-1:0] depth_dec;
  logic [LOG_PTR_BITS-1:0]  walk_prev;
  tbl_entry_t               ent;
  tbl_entry_t               new_ent;
  logic                     accept;
  logic                     out_free;
  logic                     fin;
  logic                     depth_nz;
  logic [REF_BITS-1:0]      ref_inc;
  logic [CNT_BITS-1:0]      elem_inc;

  assign accept      = item_i.valid && item_i.ready;
  assign item_i.ready = (state_q == ST_IDLE);
  assign out_free    = !out_valid_q || res_o.ready;
  assign ent         = tbl_entry_t'(tbl_rdata_i);
  assign depth_nz    = (depth_q != '0);
  assign depth_dec   = depth_q - MARK_PTR_BITS'(1);
  assign mark_top    = mark_q[depth_dec[MARK_AW-1:0]];
  assign walk_prev   = walk_ptr_q - LOG_PTR_BITS'(1);
  assign ref_inc     = (&ref_q) ? ref_q : ref_q + REF_BITS'(1);
  assign elem_inc    = (&elem_q) ? elem_q : elem_q + CNT_BITS'(1);

  // table read address follows the request while idle, then holds
  assign tbl_raddr_o = (state_q == ST_IDLE) ? item_i.id : id_q;
  assign log_raddr_o = walk_prev[LOG_AW-1:0];

  assign new_ent.valid   = 1'b1;
  assign new_ent.ref_num = ref_q;

  always_comb begin
    state_d     = state_q;
    clr_ptr_d   = clr_ptr_q;
    log_top_d   = log_top_q;
    depth_d     = depth_q;
    ref_d       = ref_q;
    elem_d      = elem_q;
    walk_ptr_d  = walk_ptr_q;
    pend_d      = 1'b0;
    mtop_d      = mtop_q;
    mcount_d    = mcount_q;
    out_valid_d = out_valid_q && !res_o.ready;
    res_d       = res_q;
    res_n       = '0;
    fin         = 1'b0;
    tbl_we_o    = 1'b0;
    tbl_waddr_o = id_q;
    tbl_wdata_o = '0;
    log_we_o    = 1'b0;
    log_waddr_o = log_top_q[LOG_AW-1:0];
    log_wdata_o = id_q;
    mark_we     = 1'b0;
    mark_wdata.top   = log_top_q;
    mark_wdata.count = elem_q;

    case (state_q)
      ST_CLEAR: begin
        tbl_we_o    = 1'b1;
        tbl_waddr_o = clr_ptr_q;
        clr_ptr_d   = clr_ptr_q + ID_BITS'(1);
        if (&clr_ptr_q) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (out_free) begin
          fin     = 1'b1;
          state_d = ST_IDLE;
          case (kind_q)
            KIND_PUT: begin
              if (ent.valid) begin
                res_n.ref_value = ent.ref_num;
                ref_d           = ref_inc;
              end else if (depth_nz && (log_top_q == LOG_PTR_BITS'(LOG_DEPTH))) begin
                res_n.error = ERR_LOG_FULL;
              end else begin
                if (depth_nz) begin
                  log_we_o  = 1'b1;
                  log_top_d = log_top_q + LOG_PTR_BITS'(1);
                end
                tbl_we_o        = 1'b1;
                tbl_wdata_o     = new_ent;
                res_n.hit       = 1'b1;
                res_n.ref_value = ref_q;
                ref_d           = ref_inc;
                elem_d          = elem_inc;
              end
            end
            KIND_COUNT: begin
              elem_d = elem_inc;
            end
            KIND_LOOKUP: begin
              if (ent.valid) begin
                res_n.hit       = 1'b1;
                res_n.ref_value = ent.ref_num;
              end
            end
            KIND_SET: begin
              if (depth_q == MARK_PTR_BITS'(MARK_DEPTH)) begin
                res_n.error = ERR_MARK_FULL;
              end else begin
                mark_we = 1'b1;
                depth_d = depth_q + MARK_PTR_BITS'(1);
              end
            end
            KIND_REVERT: begin
              if (!depth_nz) begin
                res_n.error = ERR_NO_MARK;
              end else begin
                // pop the mark and start the log walk
                fin        = 1'b0;
                state_d    = ST_WALK;
                depth_d    = depth_dec;
                mtop_d     = mark_top.top;
                mcount_d   = mark_top.count;
                walk_ptr_d = log_top_q;
              end
            end
            KIND_COMMIT: begin
              if (!depth_nz) begin
                res_n.error = ERR_NO_MARK;
              end else begin
                depth_d = depth_dec;
                if (depth_dec == '0) begin
                  log_top_d = '0;
                end
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_WALK: begin
        // log data from the previous cycle clears its table entry
        if (pend_q) begin
          tbl_we_o    = 1'b1;
          tbl_waddr_o = log_rdata_i;
          tbl_wdata_o = '0;
          if (ref_q != '0) begin
            ref_d = ref_q - REF_BITS'(1);
          end
        end
        if (walk_ptr_q > mtop_q) begin
          walk_ptr_d = walk_prev;
          pend_d     = 1'b1;
        end else if (!pend_q && out_free) begin
          fin       = 1'b1;
          state_d   = ST_IDLE;
          elem_d    = mcount_q;
          log_top_d = walk_ptr_q;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    res_n.element_count = elem_d;
    if (fin) begin
      out_valid_d = 1'b1;
      res_d       = res_n;
    end

    if (cfg_i.we) begin
      ref_d = cfg_i.ref_start;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_ptr_q   <= '0;
      log_top_q   <= '0;
      depth_q     <= '0;
      ref_q       <= '0;
      elem_q      <= '0;
      walk_ptr_q  <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_ptr_q   <= clr_ptr_d;
      log_top_q   <= log_top_d;
      depth_q     <= depth_d;
      ref_q       <= ref_d;
      elem_q      <= elem_d;
      walk_ptr_q  <= walk_ptr_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q <= item_i.kind;
      id_q   <= item_i.id;
    end
    mtop_q   <= mtop_d;
    mcount_q <= mcount_d;
    res_q    <= res_d;
    if (mark_we) begin
      mark_q[depth_q[MARK_AW-1:0]] <= mark_wdata;
    end
  end

  assign res_o.valid         = out_valid_q;
  assign res_o.hit           = res_q.hit;
  assign res_o.ref_value     = res_q.ref_value;
  assign res_o.element_count = res_q.element_count;
  assign res_o.error         = res_q.error;

endmodule

// ===== rtl/core/checkpointed_visited_set.sv =====
// ----------------------------------------------------------------------------
// checkpointed_visited_set
// visited-id table with nested checkpoints, revert walks an undo log
// ----------------------------------------------------------------------------
// put, count, lookup, set and commit run in the exec state, which loads the
//   result once the output register is free; no transaction is taken until then
// revert: walks the undo log down to the popped mark, one undo-log entry per
//   cycle, then loads the result once the output register is free
// reset: a clearing pass sweeps the table, one entry a cycle, with no request
//   taken meanwhile; register writes are taken throughout
module checkpointed_visited_set (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  cvs_in_if.sink                        item_i,
  cvs_out_if.source                     res_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [cvs_pkg::APB_AW-1:0]    paddr,
  input  logic [cvs_pkg::APB_DW-1:0]    pwdata,
  output logic [cvs_pkg::APB_DW-1:0]    prdata,
  output logic                          pready
);
  import cvs_pkg::*;

  // register block
  logic [REF_BITS-1:0]  ref_start_q;
  logic                 reg_hit;
  logic                 wr_en;
  cfg_t                 cfg;

  // table and log ram wiring
  logic                 tbl_we;
  logic [ID_BITS-1:0]   tbl_waddr;
  logic [TBL_WIDTH-1:0] tbl_wdata;
  logic [ID_BITS-1:0]   tbl_raddr;
  logic [TBL_WIDTH-1:0] tbl_rdata;
  logic                 log_we;
  logic [LOG_AW-1:0]    log_waddr;
  logic [ID_BITS-1:0]   log_wdata;
  logic [LOG_AW-1:0]    log_raddr;
  logic [ID_BITS-1:0]   log_rdata;

  // one register, word 0; higher words read as zero and ignore writes
  assign pready  = 1'b1;
  assign reg_hit = (paddr[2] == REG_REF_START);
  assign wr_en   = psel && penable && pwrite && reg_hit;
  assign prdata  = reg_hit ? APB_DW'(ref_start_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ref_start_q <= '0;
    end else if (wr_en) begin
      ref_start_q <= pwdata[REF_BITS-1:0];
    end
  end

  // a write of the start value also reloads the reference counter
  assign cfg.we        = wr_en;
  assign cfg.ref_start = pwdata[REF_BITS-1:0];

  // sequencer: owns counters, checkpoint stack and output register
  cvs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_i      (item_i),
    .res_o       (res_o),
    .cfg_i       (cfg),
    .tbl_we_o    (tbl_we),
    .tbl_waddr_o (tbl_waddr),
    .tbl_wdata_o (tbl_wdata),
    .tbl_raddr_o (tbl_raddr),
    .tbl_rdata_i (tbl_rdata),
    .log_we_o    (log_we),
    .log_waddr_o (log_waddr),
    .log_wdata_o (log_wdata),
    .log_raddr_o (log_raddr),
    .log_rdata_i (log_rdata)
  );

  // visited table: valid bit and reference number per id
  cvs_ram #(
    .WIDTH (TBL_WIDTH),
    .DEPTH (TBL_DEPTH)
  ) u_tbl_ram (
    .clk_i   (clk_i),
    .we_i    (tbl_we),
    .waddr_i (tbl_waddr),
    .wdata_i (tbl_wdata),
    .raddr_i (tbl_raddr),
    .rdata_o (tbl_rdata)
  );

  // undo log: ids inserted while a checkpoint is open
  cvs_ram #(
    .WIDTH (ID_BITS),
    .DEPTH (LOG_DEPTH)
  ) u_log_ram (
    .clk_i   (clk_i),
    .we_i    (log_we),
    .waddr_i (log_waddr),
    .wdata_i (log_wdata),
    .raddr_i (log_raddr),
    .rdata_o (log_rdata)
  );

endmodule
